FILE: rtl/core/lph_pkg.sv
// ----------------------------------------------------------------------------
// Hash table package
// Sizes, request and status codes, slot layout and sequencer states shared by
// the linear probing hash table and its channel interfaces.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int TABLE_SLOTS = 128;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int MIX_SHIFT   = 16;

    localparam logic [KEY_W-1:0]   EMPTY_KEY   = '1;
    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;
    localparam logic [KEY_W-1:0]   MIX_MUL     = 32'h045d_9f3b;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MIX,
        S_HOME,
        S_PROBE
    } t_state;

endpackage

FILE: rtl/core/lph_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one insert, lookup or remove request per beat.
// ----------------------------------------------------------------------------
interface lph_req_if;
    logic                               valid;
    logic                               ready;
    logic        [lph_pkg::REQ_W-1:0]   req_type;
    logic signed [lph_pkg::KEY_W-1:0]   req_key;
    logic signed [lph_pkg::VALUE_W-1:0] req_value;

    modport source (output valid, output req_type, output req_key, output req_value,
                    input ready);
    modport sink   (input valid, input req_type, input req_key, input req_value,
                    output ready);
endinterface

FILE: rtl/core/lph_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one status and found value per beat.
// ----------------------------------------------------------------------------
interface lph_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [lph_pkg::STATUS_W-1:0] status;
    logic signed [lph_pkg::VALUE_W-1:0]  found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

FILE: rtl/core/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Linear probing hash table
// Open addressing key-value table with insert, lookup and remove requests.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  i_req    in         req_type, req_key, req_value
//  o_rsp    out        status, found_value
//
// A request is accepted, passes twice through the shared mix multiplier,
// forms its home slot, then reads one slot per cycle through the single
// memory read port. After reset a clearing pass empties every slot before
// the first request is accepted. A held response stalls only the final
// commit; the next request is accepted while a response waits.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
    input  logic i_clk,
    input  logic i_rst_n,
    lph_req_if.sink   i_req,
    lph_rsp_if.source o_rsp
);

    localparam int IW = lph_pkg::SLOT_W;

    lph_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic            r_round, n_round;
    logic [lph_pkg::KEY_W-1:0] r_h, n_h;

    logic [lph_pkg::REQ_W-1:0]   r_type;
    logic [lph_pkg::KEY_W-1:0]   r_key;
    logic [lph_pkg::VALUE_W-1:0] r_value;

    logic                          r_out_valid;
    logic [lph_pkg::STATUS_W-1:0]  r_out_status;
    logic [lph_pkg::VALUE_W-1:0]   r_out_found;

    lph_pkg::t_slot r_mem [lph_pkg::TABLE_SLOTS];
    lph_pkg::t_slot r_rd_data;

    logic                          w_wr_en;
    logic [IW-1:0]                 w_wr_addr;
    lph_pkg::t_slot                w_wr_data;
    logic [IW-1:0]                 w_rd_addr;
    logic                          w_commit;
    logic                          w_out_free;
    logic                          w_accept;
    logic [lph_pkg::STATUS_W-1:0]  w_status;
    logic [lph_pkg::VALUE_W-1:0]   w_found;
    logic [lph_pkg::KEY_W-1:0]     w_mix_in;
    logic [lph_pkg::KEY_W-1:0]     w_product;
    logic [lph_pkg::KEY_W-1:0]     w_fold;
    logic                          w_last;
    logic                          w_done;
    logic                          w_store;
    logic                          w_erase;

    assign i_req.ready       = (r_state == lph_pkg::S_IDLE);
    assign w_accept          = i_req.valid && i_req.ready;
    assign w_out_free        = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_found;

    assign w_mix_in  = r_h ^ (r_h >> lph_pkg::MIX_SHIFT);
    assign w_product = w_mix_in * lph_pkg::MIX_MUL;
    assign w_fold    = r_h ^ (r_h >> lph_pkg::MIX_SHIFT);
    assign w_last    = (r_cnt == IW'(lph_pkg::TABLE_SLOTS - 1));
    assign w_rd_addr = n_idx;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_round   = r_round;
        n_h       = r_h;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = '{key: lph_pkg::EMPTY_KEY, value: lph_pkg::EMPTY_VALUE};
        w_commit  = 1'b0;
        w_done    = 1'b0;
        w_store   = 1'b0;
        w_erase   = 1'b0;
        w_status  = lph_pkg::ST_INVALID;
        w_found   = lph_pkg::EMPTY_VALUE;
        unique case (r_state)
            lph_pkg::S_CLEAR: begin
                w_wr_en = 1'b1;
                if (r_idx == IW'(lph_pkg::TABLE_SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = lph_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            lph_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_h     = i_req.req_key;
                    n_round = 1'b0;
                    n_state = lph_pkg::S_MIX;
                end
            end
            lph_pkg::S_MIX: begin
                n_h     = w_product;
                n_round = 1'b1;
                if (r_round) begin
                    n_state = lph_pkg::S_HOME;
                end
            end
            lph_pkg::S_HOME: begin
                n_idx   = w_fold[IW-1:0];
                n_cnt   = '0;
                n_state = lph_pkg::S_PROBE;
            end
            lph_pkg::S_PROBE: begin
                if (r_key == lph_pkg::EMPTY_KEY) begin
                    w_done = 1'b1;
                end else begin
                    case (r_type) inside
                        lph_pkg::REQ_INSERT: begin
                            if (r_rd_data.key == lph_pkg::EMPTY_KEY) begin
                                w_done   = 1'b1;
                                w_store  = 1'b1;
                                w_status = lph_pkg::ST_OK;
                            end else if (w_last) begin
                                w_done   = 1'b1;
                                w_status = lph_pkg::ST_FULL;
                            end
                        end
                        lph_pkg::REQ_LOOKUP, lph_pkg::REQ_REMOVE: begin
                            if (r_rd_data.key == r_key) begin
                                w_done   = 1'b1;
                                w_status = lph_pkg::ST_OK;
                                if (r_type == lph_pkg::REQ_LOOKUP) begin
                                    w_found = r_rd_data.value;
                                end else begin
                                    w_erase = 1'b1;
                                end
                            end else if (r_rd_data.key == lph_pkg::EMPTY_KEY || w_last) begin
                                w_done   = 1'b1;
                                w_status = lph_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            w_done = 1'b1;
                        end
                    endcase
                end
                if (w_done) begin
                    if (w_out_free) begin
                        w_commit = 1'b1;
                        w_wr_en  = w_store || w_erase;
                        if (w_store) begin
                            w_wr_data = '{key: r_key, value: r_value};
                        end
                        n_state = lph_pkg::S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = lph_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lph_pkg::S_CLEAR;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_round     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_round <= n_round;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        if (w_accept) begin
            r_type  <= i_req.req_type;
            r_key   <= i_req.req_key;
            r_value <= i_req.req_value;
        end
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_found  <= w_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

endmodule

FILE: dv/tb_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Hash table testbench
// Sends insert, lookup and remove requests to the linear probing hash table.
// Every response beat is checked against a model of the slot array kept
// here. A directed table covers reserved keys, the unused request code,
// extreme keys and values, duplicate inserts and a remove that breaks a
// probe chain. Random traffic follows. It fills the table to full, drains
// it, and runs under several patterns of idle and stall on both channels,
// one of them a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lph_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [lph_pkg::KEY_W-1:0] KEY_MAX    = 32'h7fff_ffff;
    localparam logic [lph_pkg::KEY_W-1:0] KEY_MIN    = 32'h8000_0000;
    localparam int POOL_N         = 16;
    localparam int PHASE_ITEMS    = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 2 * (4 + lph_pkg::TABLE_SLOTS);
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum {GEN_MIX, GEN_FILL, GEN_DRAIN} t_gen_mode;

    typedef struct {
        logic [lph_pkg::REQ_W-1:0]    op;
        logic [lph_pkg::KEY_W-1:0]    key;
        logic [lph_pkg::VALUE_W-1:0]  value;
        bit                           pinned;
        logic [lph_pkg::STATUS_W-1:0] pin_status;
        logic [lph_pkg::VALUE_W-1:0]  pin_value;
    } t_req_beat;

    typedef struct {
        logic [lph_pkg::STATUS_W-1:0] status;
        logic [lph_pkg::VALUE_W-1:0]  value;
    } t_rsp_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lph_req_if req_ch();
    lph_rsp_if rsp_ch();

    linear_probe_hash_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [lph_pkg::KEY_W-1:0]   model_keys [lph_pkg::TABLE_SLOTS];
    logic [lph_pkg::VALUE_W-1:0] model_vals [lph_pkg::TABLE_SLOTS];
    int                          model_live;
    logic [lph_pkg::KEY_W-1:0]   key_pool [POOL_N];
    t_rsp_beat                   expected_rsp [$];
    t_req_beat                   directed_rows [$];
    int                          errors;
    int                          req_idle_pct;
    int                          rsp_stall_pct;
    int                          rsp_hold_left;

    function automatic int home_index(logic [lph_pkg::KEY_W-1:0] k);
        logic [31:0] h;
        h = (k ^ (k >> lph_pkg::MIX_SHIFT)) * lph_pkg::MIX_MUL;
        h = (h ^ (h >> lph_pkg::MIX_SHIFT)) * lph_pkg::MIX_MUL;
        h = h ^ (h >> lph_pkg::MIX_SHIFT);
        return int'(h % lph_pkg::TABLE_SLOTS);
    endfunction

    function automatic void apply_request(input t_req_beat b, output t_rsp_beat r);
        int  idx;
        int  n;
        bit  done;
        r.status = lph_pkg::ST_INVALID;
        r.value  = lph_pkg::EMPTY_VALUE;
        done     = 1'b0;
        if (b.key != lph_pkg::EMPTY_KEY) begin
            idx = home_index(b.key);
            case (b.op) inside
                lph_pkg::REQ_INSERT: begin
                    r.status = lph_pkg::ST_FULL;
                    for (n = 0; n < lph_pkg::TABLE_SLOTS && !done; n++) begin
                        if (model_keys[idx] == lph_pkg::EMPTY_KEY) begin
                            model_keys[idx] = b.key;
                            model_vals[idx] = b.value;
                            model_live++;
                            r.status = lph_pkg::ST_OK;
                            done = 1'b1;
                        end else begin
                            idx = (idx + 1) % lph_pkg::TABLE_SLOTS;
                        end
                    end
                end
                lph_pkg::REQ_LOOKUP, lph_pkg::REQ_REMOVE: begin
                    r.status = lph_pkg::ST_NOT_FOUND;
                    for (n = 0; n < lph_pkg::TABLE_SLOTS && !done; n++) begin
                        if (model_keys[idx] == b.key) begin
                            r.status = lph_pkg::ST_OK;
                            if (b.op == lph_pkg::REQ_LOOKUP) begin
                                r.value = model_vals[idx];
                            end else begin
                                model_keys[idx] = lph_pkg::EMPTY_KEY;
                                model_vals[idx] = lph_pkg::EMPTY_VALUE;
                                model_live--;
                            end
                            done = 1'b1;
                        end else if (model_keys[idx] == lph_pkg::EMPTY_KEY) begin
                            done = 1'b1;
                        end else begin
                            idx = (idx + 1) % lph_pkg::TABLE_SLOTS;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    endfunction

    function automatic bit live_key(output logic [lph_pkg::KEY_W-1:0] k);
        int start;
        int n;
        int idx;
        bit hit;
        start = $urandom_range(lph_pkg::TABLE_SLOTS - 1);
        hit   = 1'b0;
        k     = lph_pkg::EMPTY_KEY;
        for (n = 0; n < lph_pkg::TABLE_SLOTS && !hit; n++) begin
            idx = (start + n) % lph_pkg::TABLE_SLOTS;
            if (model_keys[idx] != lph_pkg::EMPTY_KEY) begin
                k   = model_keys[idx];
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_req_beat row(logic [lph_pkg::REQ_W-1:0] op,
                                      logic [lph_pkg::KEY_W-1:0] key,
                                      logic [lph_pkg::VALUE_W-1:0] value, bit pinned,
                                      logic [lph_pkg::STATUS_W-1:0] st,
                                      logic [lph_pkg::VALUE_W-1:0] v);
        t_req_beat b;
        b.op         = op;
        b.key        = key;
        b.value      = value;
        b.pinned     = pinned;
        b.pin_status = st;
        b.pin_value  = v;
        return b;
    endfunction

    function automatic t_req_beat random_beat(t_gen_mode mode);
        t_req_beat                 b;
        int                        roll;
        logic [lph_pkg::KEY_W-1:0] k;
        b.pinned     = 1'b0;
        b.pin_status = lph_pkg::ST_OK;
        b.pin_value  = lph_pkg::EMPTY_VALUE;
        case ($urandom_range(15))
            0:       b.value = lph_pkg::EMPTY_VALUE;
            1:       b.value = '0;
            2:       b.value = KEY_MAX;
            3:       b.value = KEY_MIN;
            default: b.value = $urandom;
        endcase
        roll = $urandom_range(99);
        case (mode)
            GEN_FILL:  b.op = lph_pkg::REQ_INSERT;
            GEN_DRAIN: b.op = lph_pkg::REQ_REMOVE;
            default: begin
                if (roll < 40) begin
                    b.op = lph_pkg::REQ_INSERT;
                end else if (roll < 70) begin
                    b.op = lph_pkg::REQ_LOOKUP;
                end else if (roll < 97) begin
                    b.op = lph_pkg::REQ_REMOVE;
                end else begin
                    b.op = REQ_UNUSED;
                end
            end
        endcase
        roll = $urandom_range(99);
        if (mode == GEN_DRAIN || (mode == GEN_MIX && roll < 30)) begin
            if (!live_key(k)) begin
                k = $urandom;
            end
        end else if (mode == GEN_MIX && roll < 65) begin
            k = key_pool[$urandom_range(POOL_N - 1)];
        end else if (mode == GEN_MIX && roll < 69) begin
            k = lph_pkg::EMPTY_KEY;
        end else begin
            k = $urandom;
        end
        b.key = k;
        return b;
    endfunction

    task automatic send_request(input t_req_beat b);
        t_rsp_beat want;
        while ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= b.op;
        req_ch.req_key   <= b.key;
        req_ch.req_value <= b.value;
        do @(posedge i_clk); while (!req_ch.ready);
        apply_request(b, want);
        if (b.pinned) begin
            want.status = b.pin_status;
            want.value  = b.pin_value;
        end
        expected_rsp.push_back(want);
        @(negedge i_clk);
    endtask

    initial begin : rsp_side
        forever begin
            @(negedge i_clk);
            if (rsp_hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp_beat want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                $error("unexpected response beat: status %0d, found_value %h",
                       rsp_ch.status, rsp_ch.found_value);
                errors++;
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.found_value !== want.value) begin
                    $error("found_value: expected %h, actual %h",
                           want.value, rsp_ch.found_value);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int                        i;
        int                        ph;
        int                        n;
        logic [lph_pkg::KEY_W-1:0] k;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = lph_pkg::REQ_INSERT;
        req_ch.req_key   = '0;
        req_ch.req_value = '0;
        rsp_ch.ready     = 1'b0;
        errors           = 0;
        req_idle_pct     = 0;
        rsp_stall_pct    = 0;
        rsp_hold_left    = 0;
        model_live       = 0;
        for (i = 0; i < lph_pkg::TABLE_SLOTS; i++) begin
            model_keys[i] = lph_pkg::EMPTY_KEY;
            model_vals[i] = lph_pkg::EMPTY_VALUE;
        end

        // The upper half of the pool shares one home slot with the first entry.
        for (i = 0; i < POOL_N / 2; i++) begin
            key_pool[i] = $urandom;
        end
        for (i = POOL_N / 2; i < POOL_N; i++) begin
            do k = $urandom;
            while (home_index(k) != home_index(key_pool[0]) || k == key_pool[0]);
            key_pool[i] = k;
        end

        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, '0, '0, 1'b1,
                                    lph_pkg::ST_NOT_FOUND, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_REMOVE, '0, '0, 1'b1,
                                    lph_pkg::ST_NOT_FOUND, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_INSERT, lph_pkg::EMPTY_KEY, 1, 1'b1,
                                    lph_pkg::ST_INVALID, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, lph_pkg::EMPTY_KEY, 0, 1'b1,
                                    lph_pkg::ST_INVALID, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_REMOVE, lph_pkg::EMPTY_KEY, 0, 1'b1,
                                    lph_pkg::ST_INVALID, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(REQ_UNUSED, 5, 7, 1'b1,
                                    lph_pkg::ST_INVALID, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_INSERT, KEY_MAX, KEY_MIN, 1'b1,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, KEY_MAX, 0, 1'b1,
                                    lph_pkg::ST_OK, KEY_MIN));
        directed_rows.push_back(row(lph_pkg::REQ_INSERT, KEY_MIN, KEY_MAX, 1'b1,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, KEY_MIN, 0, 1'b1,
                                    lph_pkg::ST_OK, KEY_MAX));
        directed_rows.push_back(row(lph_pkg::REQ_INSERT, '0, lph_pkg::EMPTY_VALUE, 1'b1,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, '0, 0, 1'b1,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_INSERT, '0, '0, 1'b1,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, '0, 0, 1'b0,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_REMOVE, '0, 0, 1'b1,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, '0, 0, 1'b0,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_REMOVE, KEY_MAX, 0, 1'b1,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, KEY_MAX, 0, 1'b1,
                                    lph_pkg::ST_NOT_FOUND, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(REQ_UNUSED, KEY_MIN, KEY_MAX, 1'b1,
                                    lph_pkg::ST_INVALID, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_INSERT, key_pool[0], 32'h5555_5555, 1'b0,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_INSERT, key_pool[8], 32'haaaa_aaaa, 1'b0,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, key_pool[8], 0, 1'b0,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_REMOVE, key_pool[0], 0, 1'b0,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));
        directed_rows.push_back(row(lph_pkg::REQ_LOOKUP, key_pool[8], 0, 1'b0,
                                    lph_pkg::ST_OK, lph_pkg::EMPTY_VALUE));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i]);
        end

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    req_idle_pct  = 0;
                    rsp_stall_pct = 0;
                end
                1: begin
                    req_idle_pct  = 85;
                    rsp_stall_pct = 0;
                end
                2: begin
                    req_idle_pct  = 0;
                    rsp_stall_pct = 85;
                end
                3: begin
                    req_idle_pct  = 35;
                    rsp_stall_pct = 35;
                end
                default: begin
                    req_idle_pct  = 0;
                    rsp_stall_pct = 0;
                    rsp_hold_left = HOLD_CYCLES;
                end
            endcase
            repeat (PHASE_ITEMS) send_request(random_beat(GEN_MIX));
            if (ph == 1 || ph == 3) begin
                while (model_live < lph_pkg::TABLE_SLOTS) begin
                    send_request(random_beat(GEN_FILL));
                end
                repeat (24) send_request(random_beat(GEN_MIX));
                for (n = 0; n < 160 && model_live > 8; n++) begin
                    send_request(random_beat(GEN_DRAIN));
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lph_pkg.sv
rtl/core/lph_req_if.sv
rtl/core/lph_rsp_if.sv
rtl/core/linear_probe_hash_table.sv
dv/tb_linear_probe_hash_table.sv
